FILE: src/assert_macros.svh
// assertion macros used by the checker file bpc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/bpc_pkg.sv
// package: types, constants and register indexes of the button press classifier
`default_nettype none

package bpc_pkg;

  localparam int TRIM_LEVELS = 4;
  localparam int TRIM_W = (TRIM_LEVELS > 2) ? $clog2(TRIM_LEVELS) : 1;
  localparam int TIME_W = 32;
  localparam int TRIM_STEP_SHIFT = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = 32'd20000;
  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 32'd1500000;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHORT = 2'd1,
    ACT_LONG  = 2'd2
  } action_e;

  typedef struct packed {
    logic              pressed;
    logic [TIME_W-1:0] now_us;
  } sample_t;

  typedef struct packed {
    action_e     action;
    logic        scanlines_on;
    logic [1:0]  trim_level;
    logic [6:0]  trim_px;
    logic        save_request;
  } result_t;

endpackage

`default_nettype wire

FILE: src/bpc_if.sv
// request channel interfaces: button samples in, classification results out
`default_nettype none

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic        pressed;
  logic [31:0] now_us;

  modport source (output valid, output pressed, output now_us, input ready);
  modport sink   (input valid, input pressed, input now_us, output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        scanlines_on;
  logic [1:0]  trim_level;
  logic [6:0]  trim_px;
  logic        save_request;

  modport source (output valid, output action, output scanlines_on, output trim_level,
                  output trim_px, output save_request, input ready);
  modport sink   (input valid, input action, input scanlines_on, input trim_level,
                  input trim_px, input save_request, output ready);
endinterface

`default_nettype wire

FILE: src/bpc_in_reg.sv
// input register stage holding one button sample request
`default_nettype none

module bpc_in_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire bpc_pkg::sample_t in_sample_i,
  output logic                  in_ready_o,
  input  wire logic             out_free_i,
  output logic                  s1_valid_o,
  output bpc_pkg::sample_t      s1_sample_o
);
  import bpc_pkg::*;

  logic    valid_q, valid_d;
  sample_t sample_q;
  logic    take;

  assign in_ready_o = !valid_q || out_free_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_free_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q <= in_sample_i;
    end
  end

  assign s1_valid_o  = valid_q;
  assign s1_sample_o = sample_q;
endmodule

`default_nettype wire

FILE: src/bpc_core.sv
// debounce, press timing and settings state with the classification logic
`default_nettype none

module bpc_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bpc_pkg::TIME_W-1:0]        cfg_wdata_i,
  input  wire logic                              step_i,
  input  wire bpc_pkg::sample_t                  sample_i,
  output bpc_pkg::result_t                       result_o
);
  import bpc_pkg::*;

  logic [TIME_W-1:0] debounce_q, long_press_q;
  logic              was_pressed_q, was_pressed_d;
  logic [TIME_W-1:0] press_start_q, press_start_d;
  logic [TIME_W-1:0] last_edge_q, last_edge_d;
  logic              scan_q, scan_d;
  logic [TRIM_W-1:0] trim_q, trim_d;

  logic [TIME_W-1:0] elapsed, held;
  logic [6:0]        trim_wide;
  logic              edge_ok, long_hold;
  action_e           action;

  assign elapsed   = sample_i.now_us - last_edge_q;
  assign held      = sample_i.now_us - press_start_q;
  assign edge_ok   = (sample_i.pressed != was_pressed_q) && (elapsed >= debounce_q);
  assign long_hold = held > long_press_q;

  always_comb begin
    was_pressed_d = was_pressed_q;
    press_start_d = press_start_q;
    last_edge_d   = last_edge_q;
    scan_d        = scan_q;
    trim_d        = trim_q;
    action        = ACT_NONE;
    if (edge_ok) begin
      last_edge_d   = sample_i.now_us;
      was_pressed_d = sample_i.pressed;
      if (sample_i.pressed) begin
        press_start_d = sample_i.now_us;
      end else if (long_hold) begin
        action = ACT_LONG;
        if (trim_q == TRIM_W'(TRIM_LEVELS - 1)) begin
          trim_d = '0;
        end else begin
          trim_d = trim_q + TRIM_W'(1);
        end
      end else begin
        action = ACT_SHORT;
        scan_d = ~scan_q;
      end
    end
  end

  // level times step width, masked to the output fields
  assign trim_wide = 7'(trim_d) << TRIM_STEP_SHIFT;

  always_comb begin
    result_o.action       = action;
    result_o.scanlines_on = scan_d;
    result_o.trim_level   = trim_wide[TRIM_STEP_SHIFT +: 2];
    result_o.trim_px      = trim_wide;
    result_o.save_request = (action != ACT_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEBOUNCE_RESET;
      long_press_q  <= LONG_PRESS_RESET;
      was_pressed_q <= 1'b0;
      press_start_q <= '0;
      last_edge_q   <= '0;
      scan_q        <= 1'b0;
      trim_q        <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_DEBOUNCE) begin
        debounce_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_LONG_PRESS) begin
        long_press_q <= cfg_wdata_i;
      end
      if (step_i) begin
        was_pressed_q <= was_pressed_d;
        press_start_q <= press_start_d;
        last_edge_q   <= last_edge_d;
        scan_q        <= scan_d;
        trim_q        <= trim_d;
      end
    end
  end
endmodule

`default_nettype wire

FILE: src/bpc_out_reg.sv
// result register driving the output channel
`default_nettype none

module bpc_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s1_valid_i,
  input  wire bpc_pkg::result_t result_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bpc_pkg::result_t      out_result_o
);
  import bpc_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && s1_valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;
endmodule

`default_nettype wire

FILE: src/button_press_classifier.sv
// an accepted sample goes through the input register and then the result register
// throughput: one sample per cycle unless the output stalls, set by the bpc_core update
// a waiting result is held in the output register while the input register takes the next
// reset: asynchronous active low; clears valids, press state, scanline flag and trim level,
// and loads debounce 20000 us and long press 1500000 us
`default_nettype none

module button_press_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bpc_pkg::TIME_W-1:0]    cfg_wdata_i,
  bpc_in_if.sink                             in_i,
  bpc_out_if.source                          out_o
);
  import bpc_pkg::*;

  sample_t in_sample, s1_sample;
  result_t core_result, out_result;
  logic    s1_valid, out_free, step;

  // sample request payload as one struct
  assign in_sample.pressed = in_i.pressed;
  assign in_sample.now_us  = in_i.now_us;

  // stage one: registered sample request
  bpc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_sample_i (in_sample),
    .in_ready_o  (in_i.ready),
    .out_free_i  (out_free),
    .s1_valid_o  (s1_valid),
    .s1_sample_o (s1_sample)
  );

  // state advances exactly when the staged sample moves into the result register
  assign step = s1_valid && out_free;

  bpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .sample_i    (s1_sample),
    .result_o    (core_result)
  );

  // stage two: result register, frees when empty or taken this cycle
  bpc_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid),
    .result_i     (core_result),
    .free_o       (out_free),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_result_o (out_result)
  );

  assign out_o.action       = out_result.action;
  assign out_o.scanlines_on = out_result.scanlines_on;
  assign out_o.trim_level   = out_result.trim_level;
  assign out_o.trim_px      = out_result.trim_px;
  assign out_o.save_request = out_result.save_request;
endmodule

`default_nettype wire

FILE: src/bpc_checker.sv
// port-level checker for the button press classifier and its bind
`default_nettype none
`include "assert_macros.svh"

module bpc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] action_i,
  input wire logic       save_request_i,
  input wire logic [1:0] trim_level_i,
  input wire logic       scanlines_on_i
);
  import bpc_pkg::*;

  `ASSERT_CLKD(a_save_matches_action, clk_i, rst_ni, out_valid_i |-> (save_request_i == (action_i != ACT_NONE)), "save request does not follow action")
  `ASSERT_CLKD(a_stall_holds, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(action_i) && $stable(trim_level_i) && $stable(scanlines_on_i)), "stalled result changed")
  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")
  `ASSERT_CLKD(a_ready_when_empty, clk_i, rst_ni, (!out_valid_i && !in_valid_i) |=> in_ready_i, "input stalled with empty pipeline")
endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .action_i       (out_o.action),
  .save_request_i (out_o.save_request),
  .trim_level_i   (out_o.trim_level),
  .scanlines_on_i (out_o.scanlines_on)
);

`default_nettype wire
